### design/tekd_pkg.sv
package tekd_pkg;

   localparam int BUF_DEPTH_DEF = 32;

   localparam logic FUNC_FEED  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [7:0] ESC_BYTE   = 8'h1b;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_DEL     = 8'h7f;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BRACKET = 8'h5b;
   localparam logic [7:0] CH_SS3     = 8'h4f;
   localparam logic [7:0] CH_LT      = 8'h3c;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_PRESS   = 8'h4d;
   localparam logic [7:0] CH_RELEASE = 8'h6d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_F1      = 8'h50;
   localparam logic [7:0] CH_F4      = 8'h53;
   localparam logic [7:0] FINAL_LO   = 8'h40;
   localparam logic [7:0] FINAL_HI   = 8'h7e;
   localparam logic [7:0] CTRL_BASE  = 8'h60;
   localparam logic [7:0] CTRL_LAST  = 8'h1a;

   localparam logic [15:0] NUM_MAX     = 16'hffff;
   localparam logic [15:0] PASTE_BEGIN = 16'd200;
   localparam logic [15:0] PASTE_END   = 16'd201;

   localparam logic [4:0] KEY_CHAR      = 5'd0;
   localparam logic [4:0] KEY_ENTER     = 5'd1;
   localparam logic [4:0] KEY_BACKSPACE = 5'd2;
   localparam logic [4:0] KEY_TAB       = 5'd3;
   localparam logic [4:0] KEY_SPACE     = 5'd4;
   localparam logic [4:0] KEY_ESCAPE    = 5'd5;
   localparam logic [4:0] KEY_UP        = 5'd6;
   localparam logic [4:0] KEY_DOWN      = 5'd7;
   localparam logic [4:0] KEY_RIGHT     = 5'd8;
   localparam logic [4:0] KEY_LEFT      = 5'd9;
   localparam logic [4:0] KEY_HOME      = 5'd10;
   localparam logic [4:0] KEY_END       = 5'd11;
   localparam logic [4:0] KEY_INSERT    = 5'd12;
   localparam logic [4:0] KEY_DELETE    = 5'd13;
   localparam logic [4:0] KEY_PGUP      = 5'd14;
   localparam logic [4:0] KEY_PGDN      = 5'd15;
   localparam logic [4:0] KEY_F1        = 5'd16;
   localparam logic [4:0] KEY_F2        = 5'd17;
   localparam logic [4:0] KEY_F3        = 5'd18;
   localparam logic [4:0] KEY_F4        = 5'd19;
   localparam logic [4:0] KEY_F5        = 5'd20;
   localparam logic [4:0] KEY_F6        = 5'd21;
   localparam logic [4:0] KEY_F7        = 5'd22;
   localparam logic [4:0] KEY_F8        = 5'd23;
   localparam logic [4:0] KEY_F9        = 5'd24;
   localparam logic [4:0] KEY_F10       = 5'd25;
   localparam logic [4:0] KEY_F11       = 5'd26;
   localparam logic [4:0] KEY_F12       = 5'd27;
   localparam logic [4:0] KEY_UNKNOWN   = 5'd28;

   localparam logic [2:0] BTN_NONE       = 3'd3;
   localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
   localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

   localparam logic [1:0] ACT_PRESS   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_MOVE    = 2'd2;
   localparam logic [1:0] ACT_DRAG    = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic [4:0]  key_code;
      logic [7:0]  key_char;
      logic        mod_shift;
      logic        mod_alt;
      logic        mod_ctrl;
      logic [2:0]  mouse_button;
      logic [1:0]  mouse_action;
      logic [15:0] mouse_x;
      logic [15:0] mouse_y;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FLUSH_RD,
      ST_SCAN,
      ST_DECIDE,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic feed_fresh;
      logic append;
      logic flush_read;
      logic flush_finish;
      logic scan;
      logic decide;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic cnt_zero;
      logic cnt_full;
      logic scan_done;
      logic res_has;
      logic out_free;
   } dp_sts_type;

   function automatic rsp_type key_event(logic [4:0] code, logic [7:0] ch,
                                         logic sh, logic alt, logic ctl);
      rsp_type r;
      r           = '0;
      r.key_code  = code;
      r.key_char  = ch;
      r.mod_shift = sh;
      r.mod_alt   = alt;
      r.mod_ctrl  = ctl;
      return r;
   endfunction

   function automatic rsp_type plain_key(logic [7:0] c);
      rsp_type r;
      priority if (c == CH_CR || c == CH_LF) begin
         r = key_event(KEY_ENTER, 8'd0, 1'b0, 1'b0, 1'b0);
      end else if (c == CH_DEL || c == CH_BS) begin
         r = key_event(KEY_BACKSPACE, 8'd0, 1'b0, 1'b0, 1'b0);
      end else if (c == CH_TAB) begin
         r = key_event(KEY_TAB, 8'd0, 1'b0, 1'b0, 1'b0);
      end else if (c == CH_SPACE) begin
         r = key_event(KEY_SPACE, 8'd0, 1'b0, 1'b0, 1'b0);
      end else if (c != 8'd0 && c <= CTRL_LAST) begin
         r = key_event(KEY_CHAR, CTRL_BASE + c, 1'b0, 1'b0, 1'b1);
      end else begin
         r = key_event(KEY_CHAR, c, 1'b0, 1'b0, 1'b0);
      end
      return r;
   endfunction

   function automatic logic [15:0] sat_digit(logic [15:0] v, logic [7:0] c);
      logic [20:0] s;
      s = ({5'd0, v} << 3) + ({5'd0, v} << 1) + {17'd0, c[3:0]};
      return (s > {5'd0, NUM_MAX}) ? NUM_MAX : s[15:0];
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [4:0] tilde_code(logic [15:0] n);
      logic [4:0] k;
      unique case (n)
         16'd2:   k = KEY_INSERT;
         16'd3:   k = KEY_DELETE;
         16'd5:   k = KEY_PGUP;
         16'd6:   k = KEY_PGDN;
         16'd11:  k = KEY_F1;
         16'd12:  k = KEY_F2;
         16'd13:  k = KEY_F3;
         16'd14:  k = KEY_F4;
         16'd15:  k = KEY_F5;
         16'd17:  k = KEY_F6;
         16'd18:  k = KEY_F7;
         16'd19:  k = KEY_F8;
         16'd20:  k = KEY_F9;
         16'd21:  k = KEY_F10;
         16'd23:  k = KEY_F11;
         16'd24:  k = KEY_F12;
         default: k = KEY_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

### design/tekd_controller.sv
module tekd_controller
   import tekd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_sts_type    sts,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.is_flush) begin
               state_in = sts.cnt_zero ? ST_IDLE : ST_FLUSH_RD;
            end else if (sts.cnt_zero || sts.cnt_full) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FLUSH_RD: state_in = ST_FINISH;
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!sts.res_has || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_START: begin
            if (sts.is_flush) begin
               cmd.flush_read = !sts.cnt_zero;
            end else if (sts.cnt_zero || sts.cnt_full) begin
               cmd.feed_fresh = 1'b1;
            end else begin
               cmd.append = 1'b1;
            end
         end
         ST_FLUSH_RD: cmd.flush_finish = 1'b1;
         ST_SCAN:     cmd.scan = 1'b1;
         ST_DECIDE:   cmd.decide = 1'b1;
         ST_FINISH:   cmd.emit = sts.res_has && sts.out_free;
         default:     cmd = '0;
      endcase
   end

endmodule

### design/tekd_datapath.sv
module tekd_datapath
   import tekd_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(BUF_DEPTH);

   function automatic logic [AW-1:0] wrap(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, base} + {1'b0, off[AW-1:0]};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0] wr_data;
   logic wr_en;

   req_type in_ff, in_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in, pidx_ff, pidx_in;
   logic pv_ff, pv_in;
   logic [7:0] b1_ff, b1_in, b2_ff, b2_in, fin_ff, fin_in;
   logic csi_done_ff, csi_done_in, dig_ff, dig_in;
   logic [1:0] np_ff, np_in;
   logic [15:0] prm0_ff, prm0_in, prm1_ff, prm1_in;
   logic m_done_ff, m_done_in, m_press_ff, m_press_in, m_stop_ff, m_stop_in;
   logic [1:0] field_ff, field_in;
   logic [15:0] mv0_ff, mv0_in, mv1_ff, mv1_in, mv2_ff, mv2_in;
   rsp_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic res_has_ff, res_has_in, rsp_valid_ff, rsp_valid_in;

   logic issue_v;
   logic [7:0] d;
   logic [15:0] csi_sat, m_sat;

   rsp_type dec_res;
   logic dec_has, dec_clear, dec_dbl;
   logic np_two, sh, alt, ctl;
   logic [15:0] m1;
   logic [1:0] btn;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign issue_v = rd_idx_ff < count_ff;
   assign d       = rd_data_ff;
   assign csi_sat = sat_digit((np_ff == 2'd0) ? prm0_ff : prm1_ff, d);
   assign m_sat   = sat_digit((field_ff == 2'd0) ? mv0_ff :
                              (field_ff == 2'd1) ? mv1_ff : mv2_ff, d);

   assign sts.is_flush  = in_ff.func == FUNC_FLUSH;
   assign sts.cnt_zero  = count_ff == '0;
   assign sts.cnt_full  = count_ff >= DEPTH_C;
   assign sts.scan_done = !issue_v && !pv_ff;
   assign sts.res_has   = res_has_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // sequence decode once the scan is over
   always_comb begin
      np_two = (np_ff >= 2'd2) || (np_ff == 2'd1 && dig_ff);
      m1     = prm1_ff - 16'd1;
      sh     = 1'b0;
      alt    = 1'b0;
      ctl    = 1'b0;
      if (np_two && prm1_ff != 16'd0) begin
         sh  = m1[0];
         alt = m1[1];
         ctl = m1[2];
      end
      btn       = mv0_ff[1:0];
      dec_res   = '0;
      dec_has   = 1'b0;
      dec_clear = 1'b0;
      dec_dbl   = 1'b0;
      priority if (count_ff == CW'(2) && b1_ff != CH_BRACKET && b1_ff != CH_SS3) begin
         dec_has = 1'b1;
         if (b1_ff == ESC_BYTE) begin
            dec_dbl = 1'b1;
            dec_res = key_event(KEY_ESCAPE, 8'd0, 1'b0, 1'b0, 1'b0);
         end else begin
            dec_clear = 1'b1;
            dec_res   = key_event(KEY_CHAR, b1_ff, 1'b0, 1'b1, 1'b0);
         end
      end else if (count_ff == CW'(3) && b1_ff == CH_SS3 && b2_ff >= CH_F1
                   && b2_ff <= CH_F4) begin
         dec_has   = 1'b1;
         dec_clear = 1'b1;
         dec_res   = key_event(KEY_F1 + {3'd0, b2_ff[1:0]}, 8'd0, 1'b0, 1'b0, 1'b0);
      end else if (b1_ff == CH_BRACKET && count_ff >= CW'(4) && b2_ff == CH_LT) begin
         if (m_done_ff) begin
            dec_has   = 1'b1;
            dec_clear = 1'b1;
            dec_res.event_kind = 1'b1;
            dec_res.mod_shift  = mv0_ff[2];
            dec_res.mod_alt    = mv0_ff[3];
            dec_res.mod_ctrl   = mv0_ff[4];
            dec_res.mouse_x    = mv1_ff;
            dec_res.mouse_y    = mv2_ff;
            if (mv0_ff[6]) begin
               dec_res.mouse_button = (btn == 2'd0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
               dec_res.mouse_action = ACT_PRESS;
            end else begin
               dec_res.mouse_button = {1'b0, btn};
               if (mv0_ff[5]) begin
                  dec_res.mouse_action = ({1'b0, btn} == BTN_NONE) ? ACT_MOVE : ACT_DRAG;
               end else begin
                  dec_res.mouse_action = m_press_ff ? ACT_PRESS : ACT_RELEASE;
               end
            end
         end
      end else if (b1_ff == CH_BRACKET && csi_done_ff) begin
         dec_clear = 1'b1;
         dec_has   = 1'b1;
         unique case (fin_ff)
            "A": dec_res = key_event(KEY_UP, 8'd0, sh, alt, ctl);
            "B": dec_res = key_event(KEY_DOWN, 8'd0, sh, alt, ctl);
            "C": dec_res = key_event(KEY_RIGHT, 8'd0, sh, alt, ctl);
            "D": dec_res = key_event(KEY_LEFT, 8'd0, sh, alt, ctl);
            "H": dec_res = key_event(KEY_HOME, 8'd0, sh, alt, ctl);
            "F": dec_res = key_event(KEY_END, 8'd0, sh, alt, ctl);
            "P": dec_res = key_event(KEY_F1, 8'd0, sh, alt, ctl);
            "Q": dec_res = key_event(KEY_F2, 8'd0, sh, alt, ctl);
            "R": dec_res = key_event(KEY_F3, 8'd0, sh, alt, ctl);
            "S": dec_res = key_event(KEY_F4, 8'd0, sh, alt, ctl);
            "Z": dec_res = key_event(KEY_TAB, 8'd0, 1'b1, alt, ctl);
            "I", "O": dec_has = 1'b0;
            "~": begin
               if (prm0_ff == PASTE_BEGIN || prm0_ff == PASTE_END) begin
                  dec_has = 1'b0;
               end else begin
                  dec_res = key_event(tilde_code(prm0_ff), 8'd0, sh, alt, ctl);
               end
            end
            default: dec_res = key_event(KEY_UNKNOWN, 8'd0, sh, alt, ctl);
         endcase
      end else begin
         dec_has = 1'b0;
      end
   end

   always_comb begin
      in_in       = cmd.load ? req_data : in_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      wr_data     = ESC_BYTE;
      rd_addr     = cmd.flush_read ? head_ff : wrap(head_ff, rd_idx_ff);
      rd_idx_in   = rd_idx_ff;
      pidx_in     = pidx_ff;
      pv_in       = 1'b0;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      fin_in      = fin_ff;
      csi_done_in = csi_done_ff;
      dig_in      = dig_ff;
      np_in       = np_ff;
      prm0_in     = prm0_ff;
      prm1_in     = prm1_ff;
      m_done_in   = m_done_ff;
      m_press_in  = m_press_ff;
      m_stop_in   = m_stop_ff;
      field_in    = field_ff;
      mv0_in      = mv0_ff;
      mv1_in      = mv1_ff;
      mv2_in      = mv2_ff;
      res_in      = res_ff;
      res_has_in  = res_has_ff;

      if (cmd.load) begin
         res_has_in = 1'b0;
      end

      if (cmd.feed_fresh) begin
         if (in_ff.data_byte == ESC_BYTE) begin
            wr_en    = 1'b1;
            count_in = CW'(1);
         end else begin
            count_in   = '0;
            res_in     = plain_key(in_ff.data_byte);
            res_has_in = 1'b1;
         end
      end

      if (cmd.append) begin
         wr_en       = 1'b1;
         wr_addr     = wrap(head_ff, count_ff);
         wr_data     = in_ff.data_byte;
         count_in    = count_ff + CW'(1);
         rd_idx_in   = CW'(1);
         csi_done_in = 1'b0;
         dig_in      = 1'b0;
         np_in       = 2'd0;
         prm0_in     = '0;
         prm1_in     = '0;
         m_done_in   = 1'b0;
         m_stop_in   = 1'b0;
         field_in    = 2'd0;
         mv0_in      = '0;
         mv1_in      = '0;
         mv2_in      = '0;
      end

      if (cmd.flush_finish) begin
         res_has_in = 1'b1;
         if (count_ff == CW'(1) && d == ESC_BYTE) begin
            count_in = '0;
            res_in   = key_event(KEY_ESCAPE, 8'd0, 1'b0, 1'b0, 1'b0);
         end else begin
            head_in  = wrap(head_ff, CW'(1));
            count_in = count_ff - CW'(1);
            res_in   = plain_key(d);
         end
      end

      if (cmd.scan && issue_v) begin
         pv_in     = 1'b1;
         pidx_in   = rd_idx_ff;
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      // byte returned by the previous read
      if (pv_ff) begin
         if (pidx_ff == CW'(1)) begin
            b1_in = d;
         end
         if (pidx_ff == CW'(2)) begin
            b2_in = d;
         end
         if (pidx_ff >= CW'(2) && !csi_done_ff) begin
            if (d >= FINAL_LO && d <= FINAL_HI) begin
               csi_done_in = 1'b1;
               fin_in      = d;
            end else if (d == CH_SEMI) begin
               if (np_ff != 2'd3) begin
                  np_in = np_ff + 2'd1;
               end
               dig_in = 1'b0;
            end else if (is_digit(d)) begin
               dig_in = 1'b1;
               if (np_ff == 2'd0) begin
                  prm0_in = csi_sat;
               end else if (np_ff == 2'd1) begin
                  prm1_in = csi_sat;
               end
            end
         end
         if (pidx_ff >= CW'(3) && !m_done_ff) begin
            if (d == CH_PRESS || d == CH_RELEASE) begin
               m_done_in  = 1'b1;
               m_press_in = d == CH_PRESS;
            end else if (!m_stop_ff) begin
               if (d == CH_SEMI) begin
                  if (field_ff == 2'd2) begin
                     m_stop_in = 1'b1;
                  end else begin
                     field_in = field_ff + 2'd1;
                  end
               end else if (!is_digit(d)) begin
                  m_stop_in = 1'b1;
               end else begin
                  unique case (field_ff)
                     2'd0:    mv0_in = m_sat;
                     2'd1:    mv1_in = m_sat;
                     default: mv2_in = m_sat;
                  endcase
               end
            end
         end
      end

      if (cmd.decide) begin
         res_in     = dec_res;
         res_has_in = dec_has;
         if (dec_clear) begin
            count_in = '0;
         end
         if (dec_dbl) begin
            wr_en    = 1'b1;
            count_in = CW'(1);
         end
      end

      if (cmd.emit) begin
         res_has_in = 1'b0;
      end
   end

   always_comb begin
      rsp_data_in  = cmd.emit ? res_ff : rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         rd_idx_ff    <= '0;
         pv_ff        <= 1'b0;
         res_has_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         rd_idx_ff    <= rd_idx_in;
         pv_ff        <= pv_in;
         res_has_ff   <= res_has_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      pidx_ff     <= pidx_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      fin_ff      <= fin_in;
      csi_done_ff <= csi_done_in;
      dig_ff      <= dig_in;
      np_ff       <= np_in;
      prm0_ff     <= prm0_in;
      prm1_ff     <= prm1_in;
      m_done_ff   <= m_done_in;
      m_press_ff  <= m_press_in;
      m_stop_ff   <= m_stop_in;
      field_ff    <= field_in;
      mv0_ff      <= mv0_in;
      mv1_ff      <= mv1_in;
      mv2_ff      <= mv2_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/terminal_escape_key_decoder.sv
// a plain byte passes the start and finish states before rsp_valid; a flush
// adds the flush read state, a byte appended to a pending sequence the scan and
// decide states; throughput: one transaction at a time, the rescan of the
// pending buffer, one byte per cycle through its single read port, bounds it
// reset: synchronous, clears the pending count and the handshake state
module terminal_escape_key_decoder
   import tekd_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   tekd_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tekd_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new transaction accepted while one is in flight");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result raised without emit");

   a_decide_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> sts.scan_done)
      else $error("decode before buffer scan finished");

endmodule

### sim/tekd_checker.sv
module tekd_checker
   import tekd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      events_seen
);

   logic [7:0] seq_buf [0:31];
   int         seq_len;
   rsp_type    key_queue [$];

   function automatic rsp_type make_key(logic [4:0] code, logic [7:0] ch,
                                        logic sh, logic alt, logic ctl);
      rsp_type r;
      r           = '0;
      r.key_code  = code;
      r.key_char  = ch;
      r.mod_shift = sh;
      r.mod_alt   = alt;
      r.mod_ctrl  = ctl;
      return r;
   endfunction

   function automatic rsp_type byte_key(logic [7:0] c);
      if (c == CH_CR || c == CH_LF) return make_key(KEY_ENTER, 8'd0, 1'b0, 1'b0, 1'b0);
      if (c == CH_DEL || c == CH_BS) return make_key(KEY_BACKSPACE, 8'd0, 1'b0, 1'b0, 1'b0);
      if (c == CH_TAB) return make_key(KEY_TAB, 8'd0, 1'b0, 1'b0, 1'b0);
      if (c == CH_SPACE) return make_key(KEY_SPACE, 8'd0, 1'b0, 1'b0, 1'b0);
      if (c >= 8'd1 && c <= 8'd26) return make_key(KEY_CHAR, 8'h60 + c, 1'b0, 1'b0, 1'b1);
      return make_key(KEY_CHAR, c, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic logic [15:0] add_digit(logic [15:0] v, logic [7:0] c);
      int s;
      s = int'(v) * 10 + int'(c) - 48;
      return (s > 65535) ? 16'hffff : s[15:0];
   endfunction

   function automatic bit decode_mouse(output rsp_type o);
      int         stop_at, field;
      logic [15:0] v [0:2];
      logic [15:0] code;
      logic [1:0]  btn;
      bit          done;
      v = '{16'd0, 16'd0, 16'd0};
      stop_at = 3;
      field = 0;
      done = 0;
      while (stop_at < seq_len && seq_buf[stop_at] != CH_PRESS
             && seq_buf[stop_at] != CH_RELEASE) stop_at++;
      if (stop_at >= seq_len) return 0;
      for (int p = 3; p < stop_at && !done; p++) begin
         if (seq_buf[p] == CH_SEMI) begin
            field++;
            if (field > 2) done = 1;
         end else if (seq_buf[p] < CH_ZERO || seq_buf[p] > CH_NINE) begin
            done = 1;
         end else begin
            v[field] = add_digit(v[field], seq_buf[p]);
         end
      end
      code = v[0];
      btn = code[1:0];
      seq_len = 0;
      o = '0;
      o.event_kind = 1'b1;
      o.mod_shift = code[2];
      o.mod_alt = code[3];
      o.mod_ctrl = code[4];
      o.mouse_x = v[1];
      o.mouse_y = v[2];
      if (code[6]) begin
         o.mouse_button = (btn == 2'd0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
         o.mouse_action = ACT_PRESS;
      end else begin
         o.mouse_button = {1'b0, btn};
         if (code[5]) o.mouse_action = (btn == 2'd3) ? ACT_MOVE : ACT_DRAG;
         else o.mouse_action = (seq_buf[stop_at] == CH_PRESS) ? ACT_PRESS : ACT_RELEASE;
      end
      return 1;
   endfunction

   function automatic logic [4:0] tilde_key(logic [15:0] n);
      case (n)
         2: return KEY_INSERT;
         3: return KEY_DELETE;
         5: return KEY_PGUP;
         6: return KEY_PGDN;
         11: return KEY_F1;
         12: return KEY_F2;
         13: return KEY_F3;
         14: return KEY_F4;
         15: return KEY_F5;
         17: return KEY_F6;
         18: return KEY_F7;
         19: return KEY_F8;
         20: return KEY_F9;
         21: return KEY_F10;
         23: return KEY_F11;
         24: return KEY_F12;
         default: return KEY_UNKNOWN;
      endcase
   endfunction

   function automatic bit decode_csi(output rsp_type o);
      int          fin, np;
      logic [15:0] prm [0:3];
      bit          digit;
      logic [15:0] m;
      logic [4:0]  code;
      logic        sh, alt, ctl;
      prm = '{16'd0, 16'd0, 16'd0, 16'd0};
      np = 0;
      digit = 0;
      sh = 1'b0;
      alt = 1'b0;
      ctl = 1'b0;
      if (seq_len >= 4 && seq_buf[2] == CH_LT) return decode_mouse(o);
      fin = 2;
      while (fin < seq_len && !(seq_buf[fin] >= FINAL_LO && seq_buf[fin] <= FINAL_HI)) fin++;
      if (fin >= seq_len) return 0;
      for (int p = 2; p < fin; p++) begin
         if (seq_buf[p] == CH_SEMI) begin
            if (np < 3) np++;
            digit = 0;
         end else if (seq_buf[p] >= CH_ZERO && seq_buf[p] <= CH_NINE) begin
            prm[np] = add_digit(prm[np], seq_buf[p]);
            digit = 1;
         end
      end
      if (digit) np++;
      if (np >= 2 && prm[1] > 16'd0) begin
         m = prm[1] - 16'd1;
         sh = m[0];
         alt = m[1];
         ctl = m[2];
      end
      seq_len = 0;
      case (seq_buf[fin])
         "A": code = KEY_UP;
         "B": code = KEY_DOWN;
         "C": code = KEY_RIGHT;
         "D": code = KEY_LEFT;
         "H": code = KEY_HOME;
         "F": code = KEY_END;
         "P": code = KEY_F1;
         "Q": code = KEY_F2;
         "R": code = KEY_F3;
         "S": code = KEY_F4;
         "Z": begin
            code = KEY_TAB;
            sh = 1'b1;
         end
         "I", "O": return 0;
         "~": begin
            if (prm[0] == PASTE_BEGIN || prm[0] == PASTE_END) return 0;
            code = tilde_key(prm[0]);
         end
         default: code = KEY_UNKNOWN;
      endcase
      o = make_key(code, 8'd0, sh, alt, ctl);
      return 1;
   endfunction

   function automatic bit decode_seq(output rsp_type o);
      if (seq_len < 2) return 0;
      if (seq_len == 2 && seq_buf[1] != CH_BRACKET && seq_buf[1] != CH_SS3) begin
         if (seq_buf[1] == ESC_BYTE) begin
            seq_len = 1;
            o = make_key(KEY_ESCAPE, 8'd0, 1'b0, 1'b0, 1'b0);
            return 1;
         end
         seq_len = 0;
         o = make_key(KEY_CHAR, seq_buf[1], 1'b0, 1'b1, 1'b0);
         return 1;
      end
      if (seq_len == 3 && seq_buf[1] == CH_SS3 && seq_buf[2] >= CH_F1 && seq_buf[2] <= CH_F4) begin
         seq_len = 0;
         o = make_key(KEY_F1 + 5'(seq_buf[2] - CH_F1), 8'd0, 1'b0, 1'b0, 1'b0);
         return 1;
      end
      if (seq_buf[1] == CH_BRACKET) return decode_csi(o);
      return 0;
   endfunction

   function automatic bit predict_key(req_type r, output rsp_type o);
      logic [7:0] lead;
      if (r.func == FUNC_FLUSH) begin
         if (seq_len == 0) return 0;
         if (seq_len == 1 && seq_buf[0] == ESC_BYTE) begin
            seq_len = 0;
            o = make_key(KEY_ESCAPE, 8'd0, 1'b0, 1'b0, 1'b0);
            return 1;
         end
         lead = seq_buf[0];
         for (int i = 0; i < seq_len - 1; i++) seq_buf[i] = seq_buf[i + 1];
         seq_len--;
         o = byte_key(lead);
         return 1;
      end
      if (seq_len >= 32) seq_len = 0;
      if (seq_len > 0) begin
         seq_buf[seq_len] = r.data_byte;
         seq_len++;
         return decode_seq(o);
      end
      if (r.data_byte == ESC_BYTE) begin
         seq_buf[0] = r.data_byte;
         seq_len = 1;
         return 0;
      end
      o = byte_key(r.data_byte);
      return 1;
   endfunction

   assign outstanding = key_queue.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         seq_len = 0;
         key_queue.delete();
         mismatches <= 0;
         events_seen <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (predict_key(req_data, e)) key_queue.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            events_seen <= events_seen + 1;
            if (key_queue.size() == 0) begin
               if (mismatches < 10) $display("unexpected transaction %p", rsp_data);
               mismatches <= mismatches + 1;
            end else begin
               e = key_queue.pop_front();
               if (e !== rsp_data) begin
                  if (mismatches < 10) begin
                     $display("mismatch exp kind %0d code %0d char %h mod %b%b%b btn %0d act %0d x %0d y %0d",
                              e.event_kind, e.key_code, e.key_char, e.mod_shift, e.mod_alt,
                              e.mod_ctrl, e.mouse_button, e.mouse_action, e.mouse_x, e.mouse_y);
                     $display("         got kind %0d code %0d char %h mod %b%b%b btn %0d act %0d x %0d y %0d",
                              rsp_data.event_kind, rsp_data.key_code, rsp_data.key_char,
                              rsp_data.mod_shift, rsp_data.mod_alt, rsp_data.mod_ctrl,
                              rsp_data.mouse_button, rsp_data.mouse_action, rsp_data.mouse_x,
                              rsp_data.mouse_y);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

### sim/testbench.sv
module testbench;
   import tekd_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      mismatches, outstanding, events_seen;
   int      items = 0;
   int      sequences = 0;
   bit      idle_on = 1;
   int      stall_left = 0;

   terminal_escape_key_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   tekd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .mismatches(mismatches), .outstanding(outstanding), .events_seen(events_seen)
   );

   always #5 clock = ~clock;

   // receiver stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(input logic f, input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{func: f, data_byte: b};
      do @(posedge clock); while (req_stall);
      items++;
   endtask

   task automatic feed(input logic [7:0] b);
      send(FUNC_FEED, b);
   endtask

   task automatic feed_num(input int v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) feed(s[i]);
   endtask

   task automatic feed_str(input string s);
      for (int i = 0; i < s.len(); i++) feed(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic int rand_num();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 9);
         1: return $urandom_range(0, 300);
         2: return $urandom_range(60000, 99999);
         3: return $urandom;
         default: return $urandom_range(0, 30);
      endcase
   endfunction

   task automatic random_sequence();
      int k;
      byte unsigned finals [10] = '{"A", "B", "C", "D", "H", "F", "P", "Q", "R", "S"};
      k = $urandom_range(0, 13);
      sequences++;
      case (k)
         0, 1: feed(8'($urandom_range(0, 255)));
         2: begin
            feed(ESC_BYTE);
            feed(8'($urandom_range(0, 255)));
         end
         3: begin
            feed(ESC_BYTE);
            if ($urandom_range(0, 1)) feed(ESC_BYTE);
            send(FUNC_FLUSH, 8'($urandom_range(0, 255)));
         end
         4: begin
            feed(ESC_BYTE);
            feed(CH_SS3);
            feed(8'($urandom_range(0, 3) != 0 ? $urandom_range(CH_F1, CH_F4)
                                              : $urandom_range(0, 255)));
         end
         5, 6: begin
            feed(ESC_BYTE);
            feed(CH_BRACKET);
            if ($urandom_range(0, 1)) begin
               feed_num(rand_num());
               feed(CH_SEMI);
               feed_num($urandom_range(0, 3) ? $urandom_range(1, 16) : rand_num());
            end
            feed(8'($urandom_range(0, 4) ? finals[$urandom_range(0, 9)]
                                         : $urandom_range(FINAL_LO, FINAL_HI)));
         end
         7, 8: begin
            feed(ESC_BYTE);
            feed(CH_BRACKET);
            feed_num($urandom_range(0, 5) ? $urandom_range(0, 25)
                                          : ($urandom_range(0, 1) ? $urandom_range(200, 201)
                                                                  : rand_num()));
            if ($urandom_range(0, 1)) begin
               feed(CH_SEMI);
               feed_num($urandom_range(0, 9));
            end
            feed(FINAL_HI);
         end
         9: begin
            feed(ESC_BYTE);
            feed(CH_BRACKET);
            feed($urandom_range(0, 1) ? "I" : "O");
         end
         10, 11: begin
            feed(ESC_BYTE);
            feed(CH_BRACKET);
            feed(CH_LT);
            feed_num($urandom_range(0, 1) ? $urandom_range(0, 127) : rand_num());
            for (int i = 0; i < $urandom_range(0, 3); i++) begin
               feed(CH_SEMI);
               feed_num(rand_num());
            end
            if ($urandom_range(0, 7) == 0) feed(8'($urandom_range(0, 255)));
            feed($urandom_range(0, 1) ? CH_PRESS : CH_RELEASE);
         end
         12: begin
            // run up to and past the buffer depth
            feed(ESC_BYTE);
            feed(CH_BRACKET);
            repeat ($urandom_range(28, 34)) feed(8'(CH_ZERO + $urandom_range(0, 9)));
         end
         default: begin
            repeat ($urandom_range(1, 4)) send(1'($urandom_range(0, 1)),
                                               8'($urandom_range(0, 255)));
         end
      endcase
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send(FUNC_FLUSH, 8'h00);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send(FUNC_FLUSH, 8'hff);
      feed(CH_CR); feed(CH_LF); feed(CH_DEL); feed(CH_BS); feed(CH_TAB); feed(CH_SPACE);
      feed(8'h00); feed(8'h01); feed(CTRL_LAST); feed(8'hff);
      feed(ESC_BYTE); feed("a");
      feed(ESC_BYTE); feed(ESC_BYTE); send(FUNC_FLUSH, 8'h00);
      feed(ESC_BYTE); feed(CH_SS3); feed(CH_F1);
      feed(ESC_BYTE); feed_str("[1;5C");
      feed(ESC_BYTE); feed_str("[3~");
      feed(ESC_BYTE); feed_str("[200~");
      feed(ESC_BYTE); feed_str("[I");
      feed(ESC_BYTE); feed_str("[Z");
      feed(ESC_BYTE); feed_str("[<0;10;20M");
      feed(ESC_BYTE); feed_str("[<64;70000;1m");
      feed(ESC_BYTE); feed_str("Ox");
      repeat (4) send(FUNC_FLUSH, 8'h00);
      drain();
      while (items < 600) begin
         if (items > 500) idle_on = 0;
         random_sequence();
         if (items > 250 && items < 280) drain();
      end
      drain();
      $display("fed %0d bytes and flushes in %0d random sequences, %0d events checked",
               items, sequences, events_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
